// ----- design/osbox_pkg.sv -----
// Package for the one-sided box filter pass: shared types, register indexes
// and the pairing tables for the half-window sums. No dependencies.
package osbox_pkg;

  localparam int NUM_LANES  = 3;
  localparam int MAX_HEIGHT = 2048;
  localparam int CHAN_W     = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Item function codes.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Pairs of box distances that make up each half-window sum.
  localparam logic [1:0] PAIR_A [4] = '{2'd0, 2'd2, 2'd0, 2'd1};
  localparam logic [1:0] PAIR_B [4] = '{2'd1, 2'd3, 2'd2, 2'd3};

  typedef logic [CHAN_W-1:0] chan_t;

  // Which of the four boxes a window sample belongs to.
  typedef struct packed {
    logic valid;
    logic top;
    logic bot;
    logic left;
    logic right;
    logic centre;
  } tap_t;

  typedef struct packed {
    logic clear;
    logic start;
    tap_t tap;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_SEND
  } seq_state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_QUO,
    DV_QN,
    DV_CHK,
    DV_DIFF,
    DV_PICK,
    DV_DONE
  } div_state_e;

endpackage

// ----- design/osbox_lane.sv -----
// One colour lane: accumulates the four box sums of a window scan, divides
// them into rounded means and picks the filtered value. Uses osbox_pkg.
module osbox_lane import osbox_pkg::*; #(
  parameter int MAX_RADIUS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lane_ctrl_t                         ctrl_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]    radius_i,
  input  chan_t                              data_i,
  output chan_t                              result_o,
  output logic                               done_o
);

  localparam int MAXN  = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
  localparam int SUM_W = CHAN_W + $clog2(MAXN);
  localparam int NW    = $clog2(MAXN + 1);
  localparam int QW    = CHAN_W + 1 + NW;

  logic [SUM_W-1:0] n_tab [MAX_RADIUS+1];
  logic [SUM_W-1:0] k_tab [MAX_RADIUS+1];

  // Reciprocal of the box area for every radius, worked out at elaboration.
  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_tab
    localparam longint unsigned NV = (g + 1) * (g + 1);
    localparam longint unsigned KV = (64'd1 << SUM_W) / NV;
    assign n_tab[g] = SUM_W'(NV);
    assign k_tab[g] = SUM_W'(KV);
  end

  div_state_e         state_q, state_d;
  logic [SUM_W-1:0]   sum_q [4];
  chan_t              c_q;
  chan_t              m_q [4];
  logic [1:0]         k_q;
  logic [SUM_W-1:0]   n_q, kr_q, s_q;
  logic [2*SUM_W-1:0] prod_q;
  logic [CHAN_W:0]    q_q;
  logic [QW-1:0]      qn_q;
  logic signed [CHAN_W:0]   d_q [4];
  logic signed [CHAN_W+1:0] e_q [4];
  chan_t              res_q;

  logic [QW-1:0]      rem;
  logic [CHAN_W:0]    ad [4];
  logic [CHAN_W+1:0]  ae [4];
  logic [1:0]         i1, i2;
  logic [CHAN_W+1:0]  two_d;
  logic [CHAN_W:0]    half_sum;
  chan_t              pick;

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: if (ctrl_i.start) state_d = DV_MUL;
      DV_MUL:  state_d = DV_QUO;
      DV_QUO:  state_d = DV_QN;
      DV_QN:   state_d = DV_CHK;
      DV_CHK:  state_d = (k_q == 2'd3) ? DV_DIFF : DV_MUL;
      DV_DIFF: state_d = DV_PICK;
      DV_PICK: state_d = DV_DONE;
      DV_DONE: state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    done_o   = (state_q == DV_DONE);
    result_o = res_q;
  end

  // Division correction: the reciprocal estimate is at most one short.
  assign rem = QW'(s_q) - qn_q;

  // Least-magnitude selections, lowest index winning ties.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ad[k] = d_q[k][CHAN_W] ? (CHAN_W+1)'(-d_q[k]) : (CHAN_W+1)'(d_q[k]);
      ae[k] = e_q[k][CHAN_W+1] ? (CHAN_W+2)'(-e_q[k]) : (CHAN_W+2)'(e_q[k]);
    end
    i1 = 2'd0;
    i2 = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (ad[k] < ad[i1]) i1 = 2'(k);
      if (ae[k] < ae[i2]) i2 = 2'(k);
    end
    two_d    = {ad[i1], 1'b0};
    half_sum = (CHAN_W+1)'(m_q[PAIR_A[i2]]) + (CHAN_W+1)'(m_q[PAIR_B[i2]]) + 1'b1;
    pick     = (two_d < ae[i2]) ? m_q[i1] : half_sum[CHAN_W:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      for (int k = 0; k < 4; k++) sum_q[k] <= '0;
    end else if (ctrl_i.tap.valid) begin
      if (ctrl_i.tap.top && ctrl_i.tap.left)  sum_q[0] <= sum_q[0] + SUM_W'(data_i);
      if (ctrl_i.tap.top && ctrl_i.tap.right) sum_q[1] <= sum_q[1] + SUM_W'(data_i);
      if (ctrl_i.tap.bot && ctrl_i.tap.left)  sum_q[2] <= sum_q[2] + SUM_W'(data_i);
      if (ctrl_i.tap.bot && ctrl_i.tap.right) sum_q[3] <= sum_q[3] + SUM_W'(data_i);
      if (ctrl_i.tap.centre) c_q <= data_i;
    end
    case (state_q)
      DV_IDLE: begin
        k_q  <= 2'd0;
        n_q  <= n_tab[radius_i];
        kr_q <= k_tab[radius_i];
      end
      DV_MUL: begin
        s_q    <= sum_q[k_q] + {1'b0, n_q[SUM_W-1:1]};
        prod_q <= (2*SUM_W)'(sum_q[k_q] + {1'b0, n_q[SUM_W-1:1]}) * (2*SUM_W)'(kr_q);
      end
      DV_QUO: q_q  <= prod_q[SUM_W +: CHAN_W+1];
      DV_QN:  qn_q <= QW'(q_q) * QW'(n_q);
      DV_CHK: begin
        m_q[k_q] <= (rem >= QW'(n_q)) ? CHAN_W'(q_q + 1'b1) : CHAN_W'(q_q);
        k_q      <= k_q + 2'd1;
      end
      DV_DIFF: begin
        for (int k = 0; k < 4; k++) begin
          d_q[k] <= $signed({1'b0, m_q[k]}) - $signed({1'b0, c_q});
        end
        for (int k = 0; k < 4; k++) begin
          e_q[k] <= (CHAN_W+2)'($signed({1'b0, m_q[PAIR_A[k]]}) - $signed({1'b0, c_q}))
                  + (CHAN_W+2)'($signed({1'b0, m_q[PAIR_B[k]]}) - $signed({1'b0, c_q}));
        end
      end
      DV_PICK: res_q <= pick;
      default: ;
    endcase
  end

endmodule

// ----- design/osbox_merge.sv -----
// Merging stage: gathers the three lane results and the frame end flag into
// the output register that faces the result channel. Uses osbox_pkg.
module osbox_merge import osbox_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  chan_t lane_res_i [NUM_LANES],
  input  logic  frame_end_i,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  output chan_t red_out_o,
  output chan_t green_out_o,
  output chan_t blue_out_o,
  output logic  frame_end_o,
  output logic  free_o
);

  logic  valid_q;
  chan_t red_q, green_q, blue_q;
  logic  fe_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign frame_end_o = fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      red_q   <= lane_res_i[0];
      green_q <= lane_res_i[1];
      blue_q  <= lane_res_i[2];
      fe_q    <= frame_end_i;
    end
  end

endmodule

// ----- design/one_sided_box_filter_pass_core.sv -----
// Top level of the one-sided box filter pass: sequencer, line store, address
// pipeline, three colour lanes and the merging stage. Uses osbox_pkg.
//
// The block takes RGB pixels in raster order and emits each filtered pixel
// R+1 rows after it went in, at most one result per request on the result
// channel; flush requests drain the last R+1 rows and the pixel marked
// frame_end closes the frame. A request that yields a result reads the window
// around the output pixel from the line store one sample per cycle through its
// single read port; the read pipeline then drains, each lane turns its four
// box sums into means through its own reciprocal divider (multiply, quotient
// and correction for each mean, then the decision), and the result is loaded.
// A finished result waits in the output register, so a new request is taken
// while it is still pending. The line store holds 2*MAX_RADIUS+2 rows and is
// not cleared after reset; it is always written before it is read.
module one_sided_box_filter_pass_core import osbox_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  chan_t       red_in_i,
  input  chan_t       green_in_i,
  input  chan_t       blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output chan_t       red_out_o,
  output chan_t       green_out_o,
  output chan_t       blue_out_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SW        = $clog2(RING_ROWS);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int RBW       = $clog2(MAX_RADIUS + 1);
  localparam int DW        = RBW + 1;
  localparam int XSW       = ((CW > DW) ? CW : DW) + 2;
  localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int RECIP_SH  = 24;
  localparam int RECIP     = ((1 << RECIP_SH) + RING_ROWS - 1) / RING_ROWS;

  // Configuration registers.
  logic [3:0]  radius_q;
  logic [11:0] width_q, height_q;

  // Effective (clamped) settings.
  logic [RBW-1:0] eff_r;
  logic [WW-1:0]  eff_w;
  logic [11:0]    eff_h;

  // Frame position counters.
  logic [11:0]   in_row_q, in_row_d;
  logic [CW-1:0] in_col_q, in_col_d;
  logic [SW-1:0] in_slot_q, in_slot_d;
  logic [10:0]   out_row_q, out_row_d;
  logic [CW-1:0] out_col_q, out_col_d;

  seq_state_e state_q, state_d;
  logic       accept, is_pixel, do_write, do_produce, fe_d;
  logic [10:0]   y_d;
  logic [CW-1:0] x_d, wcol;
  logic [10:0]   y_q;
  logic [CW-1:0] x_q;
  logic          fe_q;

  // Window scan counters and read address pipeline.
  logic signed [DW-1:0] dy_q, dx_q, neg_r, pos_r;
  logic                 scan_last, issue, lanes_start, merge_load, merge_free;
  logic signed [12:0]   sy;
  logic signed [XSW-1:0] sx;
  logic [10:0]          t_d, t_q;
  logic [CW-1:0]        u_d, u_q;
  tap_t                 tap_d, tap_a_q, tap_b_q, tap_c_q;
  logic [35:0]          mod_prod;
  logic [11:0]          mod_quo;
  logic [SW-1:0]        rd_slot;
  logic [AW-1:0]        raddr_q, waddr;

  logic [3*CHAN_W-1:0]  store [DEPTH];
  logic [3*CHAN_W-1:0]  rd_q;

  lane_ctrl_t lane_ctrl;
  chan_t      lane_res [NUM_LANES];
  logic       lane_done [NUM_LANES];

  // Out-of-range settings act as the nearest legal value.
  always_comb begin
    if (radius_q == 4'd0)                eff_r = RBW'(1);
    else if (int'(radius_q) > MAX_RADIUS) eff_r = RBW'(MAX_RADIUS);
    else                                 eff_r = RBW'(radius_q);
    if (width_q == 12'd0)                eff_w = WW'(1);
    else if (int'(width_q) > MAX_WIDTH)  eff_w = WW'(MAX_WIDTH);
    else                                 eff_w = WW'(width_q);
    if (height_q == 12'd0)               eff_h = 12'd1;
    else if (int'(height_q) > MAX_HEIGHT) eff_h = 12'(MAX_HEIGHT);
    else                                 eff_h = height_q;
  end

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign is_pixel    = (func_i == FUNC_PIXEL);

  // Counter updates for one accepted request. A pixel beyond the last row is
  // dropped; a flush only yields a result once the whole frame is in.
  always_comb begin
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    do_write   = 1'b0;
    do_produce = 1'b0;
    fe_d       = 1'b0;
    wcol       = (WW'(in_col_q) < eff_w) ? in_col_q : CW'(eff_w - WW'(1));
    y_d        = (12'(out_row_q) >= eff_h) ? 11'(eff_h - 12'd1) : out_row_q;
    x_d        = (WW'(out_col_q) >= eff_w) ? CW'(eff_w - WW'(1)) : out_col_q;
    if (accept) begin
      if (is_pixel) begin
        if (in_row_q < eff_h) begin
          do_write   = 1'b1;
          do_produce = (in_row_q >= 12'(eff_r) + 12'd1);
          if (WW'(in_col_q) + WW'(1) >= eff_w) begin
            in_col_d  = '0;
            in_row_d  = in_row_q + 12'd1;
            in_slot_d = (in_slot_q == SW'(RING_ROWS - 1)) ? '0 : in_slot_q + SW'(1);
          end else begin
            in_col_d = in_col_q + CW'(1);
          end
        end
      end else begin
        do_produce = (in_row_q >= eff_h);
      end
      if (do_produce) begin
        if (WW'(out_col_q) + WW'(1) >= eff_w) begin
          out_col_d = '0;
          if (12'(out_row_q) + 12'd1 >= eff_h) begin
            fe_d      = 1'b1;
            out_row_d = '0;
            in_row_d  = '0;
            in_col_d  = '0;
            in_slot_d = '0;
          end else begin
            out_row_d = out_row_q + 11'd1;
          end
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  assign neg_r     = -$signed({1'b0, eff_r});
  assign pos_r     = $signed({1'b0, eff_r});
  assign scan_last = (dy_q == pos_r) && (dx_q == pos_r);

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && do_produce) state_d = ST_SCAN;
      ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
      ST_DRAIN: if (!tap_a_q.valid && !tap_b_q.valid && !tap_c_q.valid) state_d = ST_DIV;
      ST_DIV:   if (lane_done[0]) state_d = ST_SEND;
      ST_SEND:  if (merge_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    issue       = (state_q == ST_SCAN);
    lanes_start = (state_q == ST_DRAIN) && !tap_a_q.valid && !tap_b_q.valid
                  && !tap_c_q.valid;
    merge_load  = (state_q == ST_SEND) && merge_free;
  end

  // Window sample position, clamped into the frame.
  always_comb begin
    sy = $signed({2'b00, y_q}) + 13'(dy_q);
    if (sy < 0)                              t_d = '0;
    else if (sy > $signed({1'b0, eff_h - 12'd1})) t_d = 11'(eff_h - 12'd1);
    else                                     t_d = sy[10:0];
    sx = $signed(XSW'({2'b00, x_q})) + XSW'(dx_q);
    if (sx < 0)                              u_d = '0;
    else if (sx > $signed(XSW'(eff_w - WW'(1)))) u_d = CW'(eff_w - WW'(1));
    else                                     u_d = sx[CW-1:0];
    tap_d.valid  = issue;
    tap_d.top    = (dy_q >= 0);
    tap_d.bot    = (dy_q <= 0);
    tap_d.left   = (dx_q <= 0);
    tap_d.right  = (dx_q >= 0);
    tap_d.centre = (dy_q == 0) && (dx_q == 0);
  end

  // Row to ring slot by reciprocal multiplication; exact for all row numbers.
  assign mod_prod = 36'(t_q) * 36'(RECIP);
  assign mod_quo  = mod_prod[RECIP_SH +: 12];
  assign rd_slot  = SW'(12'(t_q) - mod_quo * 12'(RING_ROWS));
  assign waddr    = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(wcol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 4'd1;
      width_q   <= 12'd640;
      height_q  <= 12'd480;
      state_q   <= ST_IDLE;
      in_row_q  <= '0;
      in_col_q  <= '0;
      in_slot_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      tap_a_q   <= '0;
      tap_b_q   <= '0;
      tap_c_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_RADIUS: radius_q <= cfg_data_i[3:0];
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      state_q   <= state_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      in_slot_q <= in_slot_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      tap_a_q   <= tap_d;
      tap_b_q   <= tap_a_q;
      tap_c_q   <= tap_b_q;
    end
  end

  // Payload registers of the sequencer and address pipeline.
  always_ff @(posedge clk_i) begin
    if (accept && do_produce) begin
      y_q  <= y_d;
      x_q  <= x_d;
      fe_q <= fe_d;
      dy_q <= neg_r;
      dx_q <= neg_r;
    end else if (issue) begin
      if (dx_q == pos_r) begin
        dx_q <= neg_r;
        dy_q <= dy_q + DW'(1);
      end else begin
        dx_q <= dx_q + DW'(1);
      end
    end
    t_q     <= t_d;
    u_q     <= u_d;
    raddr_q <= AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(u_q);
  end

  // Line store: one write port for incoming pixels, one registered read port.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      store[waddr] <= {blue_in_i, green_in_i, red_in_i};
    end
    rd_q <= store[raddr_q];
  end

  always_comb begin
    lane_ctrl.clear = accept && do_produce;
    lane_ctrl.start = lanes_start;
    lane_ctrl.tap   = tap_c_q;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    osbox_lane #(
      .MAX_RADIUS (MAX_RADIUS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .radius_i (eff_r),
      .data_i   (rd_q[l*CHAN_W +: CHAN_W]),
      .result_o (lane_res[l]),
      .done_o   (lane_done[l])
    );
  end

  osbox_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (merge_load),
    .lane_res_i  (lane_res),
    .frame_end_i (fe_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o),
    .free_o      (merge_free)
  );

endmodule

// ----- design/osbox_checker.sv -----
// Port-level checks for the one-sided box filter pass, bound to the top
// level. Uses osbox_pkg for the payload type.
module osbox_checker import osbox_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input chan_t red_out_o,
  input chan_t green_out_o,
  input chan_t blue_out_o,
  input logic  frame_end_o
);

  // A pending result is held until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({red_out_o, green_out_o, blue_out_o,
                                             frame_end_o}))
    else $error("result changed while stalled");

  // The block stops taking requests only after it has just taken one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("input stalled without a request");

  // A new result is only loaded while the input side is busy with its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in progress");

endmodule

bind one_sided_box_filter_pass_core osbox_checker u_osbox_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for one_sided_box_filter_pass_core.
// Drives whole frames of random RGB pixels plus flush requests, predicts every
// filtered pixel with a behavioural model of the filter, and checks the results.
`timescale 1ns / 100ps

module tb_top;
  import osbox_pkg::*;

  localparam int RING   = 18;
  localparam int MAXW   = 2048;
  localparam int MAXR   = 8;
  localparam int SETTLE = 400;

  typedef struct {
    logic  func;
    chan_t red;
    chan_t green;
    chan_t blue;
  } px_req_t;

  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  fe;
  } px_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  func = FUNC_PIXEL;
  chan_t red_in = '0, green_in = '0, blue_in = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  chan_t red_out, green_out, blue_out;
  logic  frame_end;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [1:0]  cfg_index = REG_RADIUS;
  logic [11:0] cfg_data = '0;

  one_sided_box_filter_pass_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .func_i(func),
    .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .red_out_o(red_out), .green_out_o(green_out), .blue_out_o(blue_out),
    .frame_end_o(frame_end),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests waiting to be offered, and filtered pixels still to be seen.
  px_req_t pend_q[$];
  px_res_t filt_q[$];
  int unsigned sent_cnt = 0, acc_cnt = 0, cfg_acc = 0;
  int unsigned fails = 0;
  bit idle_en = 1'b1;
  bit hold_go = 1'b0;

  // ---------------------------------------------------------------------
  // Behavioural model of the filter: its own line store, counters and
  // register copies, updated on every accepted request.
  // ---------------------------------------------------------------------
  bit [15:0] line_mem [RING][MAXW][3];
  int unsigned m_rad = 1, m_w = 640, m_h = 480;
  int unsigned m_in_row = 0, m_in_col = 0, m_out_row = 0, m_out_col = 0;

  function automatic int eff_rad();
    return (m_rad < 1) ? 1 : (m_rad > MAXR) ? MAXR : m_rad;
  endfunction

  function automatic int eff_w();
    return (m_w < 1) ? 1 : (m_w > MAXW) ? MAXW : m_w;
  endfunction

  function automatic int eff_h();
    return (m_h < 1) ? 1 : (m_h > MAX_HEIGHT) ? MAX_HEIGHT : m_h;
  endfunction

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int box_avg(int ch, int y0, int x0, int r, int w, int h);
    int unsigned acc, n;
    acc = 0;
    n = (r + 1) * (r + 1);
    for (int dy = 0; dy <= r; dy++)
      for (int dx = 0; dx <= r; dx++)
        acc += line_mem[clip(y0 + dy, h - 1) % RING][clip(x0 + dx, w - 1)][ch];
    return (acc + n / 2) / n;
  endfunction

  // Filters the pixel at the output cursor and advances that cursor.
  function automatic px_res_t filter_next();
    px_res_t res;
    int r, w, h, y, x, c, i1, i2, v;
    int mn [4];
    int d [4];
    int e [4];
    chan_t lane [3];
    r = eff_rad();
    w = eff_w();
    h = eff_h();
    y = clip((m_out_row > MAX_HEIGHT) ? MAX_HEIGHT : m_out_row, h - 1);
    x = clip((m_out_col > MAXW) ? MAXW : m_out_col, w - 1);
    for (int ch = 0; ch < 3; ch++) begin
      c = line_mem[y % RING][x][ch];
      mn[0] = box_avg(ch, y, x - r, r, w, h);
      mn[1] = box_avg(ch, y, x, r, w, h);
      mn[2] = box_avg(ch, y - r, x - r, r, w, h);
      mn[3] = box_avg(ch, y - r, x, r, w, h);
      for (int k = 0; k < 4; k++) d[k] = mn[k] - c;
      for (int k = 0; k < 4; k++) e[k] = d[PAIR_A[k]] + d[PAIR_B[k]];
      i1 = 0;
      i2 = 0;
      for (int k = 1; k < 4; k++) begin
        if (iabs(d[k]) < iabs(d[i1])) i1 = k;
        if (iabs(e[k]) < iabs(e[i2])) i2 = k;
      end
      // A single box wins only when it is clearly closer than the best half.
      if (2 * iabs(d[i1]) < iabs(e[i2])) v = mn[i1];
      else v = (mn[PAIR_A[i2]] + mn[PAIR_B[i2]] + 1) >>> 1;
      lane[ch] = v[15:0];
    end
    res.red = lane[0];
    res.green = lane[1];
    res.blue = lane[2];
    res.fe = 1'b0;
    if (m_out_col + 1 >= w) begin
      m_out_col = 0;
      if (m_out_row + 1 >= h) begin
        res.fe = 1'b1;
        m_out_row = 0;
        m_in_row = 0;
        m_in_col = 0;
      end else begin
        m_out_row++;
      end
    end else begin
      m_out_col++;
    end
    return res;
  endfunction

  // Applies one accepted request; returns 1 when it yields a filtered pixel.
  function automatic bit model_request(px_req_t rq, output px_res_t res);
    int w, h, col;
    bit emit;
    w = eff_w();
    h = eff_h();
    res = '{default: '0};
    if (rq.func == FUNC_PIXEL) begin
      // Pixels that arrive while the tail is being flushed are dropped.
      if (m_in_row >= h) return 1'b0;
      col = (m_in_col < w) ? m_in_col : w - 1;
      line_mem[m_in_row % RING][col][0] = rq.red;
      line_mem[m_in_row % RING][col][1] = rq.green;
      line_mem[m_in_row % RING][col][2] = rq.blue;
      emit = (m_in_row >= eff_rad() + 1);
      if (m_in_col + 1 >= w) begin
        m_in_col = 0;
        m_in_row++;
      end else begin
        m_in_col++;
      end
      if (!emit) return 1'b0;
      res = filter_next();
      return 1'b1;
    end
    // A flush before the frame's input is complete does nothing.
    if (m_in_row < h) return 1'b0;
    res = filter_next();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!idle_en || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: changes inputs on the falling edge only.
  // ---------------------------------------------------------------------
  int in_gap = 0;
  always @(negedge clk) begin
    px_req_t rq;
    if (rst_n) begin
      if (in_valid && sent_cnt != acc_cnt) begin
        // Still waiting for the block to take the current request.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        rq = pend_q.pop_front();
        func <= rq.func;
        red_in <= rq.red;
        green_in <= rq.green;
        blue_in <= rq.blue;
        in_valid <= 1'b1;
        sent_cnt <= sent_cnt + 1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off when asked.
  int out_gap = 0, hold_left = 0;
  bit hold_seen = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_go != hold_seen) begin
        hold_seen <= hold_go;
        hold_left <= 600;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every handshake is observed on the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    px_req_t rq;
    px_res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIUS: m_rad = cfg_data[3:0];
          REG_WIDTH:  m_w = cfg_data;
          REG_HEIGHT: m_h = cfg_data;
          default: ;
        endcase
        cfg_acc <= cfg_acc + 1;
      end
      if (in_valid && in_ready) begin
        rq = '{func, red_in, green_in, blue_in};
        if (model_request(rq, want)) filt_q.push_back(want);
        acc_cnt <= acc_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (filt_q.size() == 0) begin
          $error("unexpected result: red %h green %h blue %h frame_end %b",
                 red_out, green_out, blue_out, frame_end);
          fails++;
        end else begin
          want = filt_q.pop_front();
          if (red_out !== want.red) begin
            $error("red_out: expected %h, got %h", want.red, red_out);
            fails++;
          end
          if (green_out !== want.green) begin
            $error("green_out: expected %h, got %h", want.green, green_out);
            fails++;
          end
          if (blue_out !== want.blue) begin
            $error("blue_out: expected %h, got %h", want.blue, blue_out);
            fails++;
          end
          if (frame_end !== want.fe) begin
            $error("frame_end: expected %b, got %b", want.fe, frame_end);
            fails++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------
  function automatic chan_t rand_chan();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return chan_t'($urandom());
    endcase
  endfunction

  function automatic px_req_t rand_px();
    return '{FUNC_PIXEL, rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // Queues one complete frame and the flushes that drain its tail. With noise,
  // early flushes and pixels sent during the tail are mixed in; both are ignored.
  task automatic add_frame(int w, int h, int r, bit noise);
    int tail;
    px_req_t fl;
    fl = '{FUNC_FLUSH, chan_t'($urandom()), chan_t'($urandom()), chan_t'($urandom())};
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(0, 19) == 0) pend_q.push_back(fl);
      pend_q.push_back(rand_px());
    end
    tail = (h > r + 1) ? w * (r + 1) : w * h;
    for (int i = 0; i < tail; i++) begin
      if (noise && $urandom_range(0, 14) == 0) pend_q.push_back(rand_px());
      pend_q.push_back(fl);
    end
  endtask

  // Waits until every request is taken and every result has come back, then
  // lets the block settle before any register is touched.
  task automatic drain();
    while (pend_q.size() != 0 || sent_cnt != acc_cnt || filt_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [11:0] val);
    int unsigned target;
    target = cfg_acc + 1;
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    while (cfg_acc != target) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(int r, int w, int h);
    reg_write(REG_RADIUS, 12'(r));
    reg_write(REG_WIDTH, 12'(w));
    reg_write(REG_HEIGHT, 12'(h));
  endtask

  initial begin
    int r, w, h, rand_cnt;
    px_req_t fl;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);

    // Directed: small frame of extreme values, with a flush before the frame
    // is complete and a pixel offered during the tail.
    set_frame(1, 4, 5);
    fl = '{FUNC_FLUSH, 16'hFFFF, 16'h0000, 16'hFFFF};
    pend_q.push_back(fl);
    for (int i = 0; i < 20; i++) begin
      case (i % 5)
        0: pend_q.push_back('{FUNC_PIXEL, 16'h0000, 16'hFFFF, 16'h0000});
        1: pend_q.push_back('{FUNC_PIXEL, 16'hFFFF, 16'h0000, 16'hFFFF});
        2: pend_q.push_back('{FUNC_PIXEL, 16'h8000, 16'h7FFF, 16'h0001});
        3: pend_q.push_back('{FUNC_PIXEL, 16'h5555, 16'hAAAA, 16'hFFFE});
        default: pend_q.push_back(rand_px());
      endcase
    end
    pend_q.push_back(rand_px());
    for (int i = 0; i < 8; i++) pend_q.push_back(fl);
    drain();

    // Out-of-range registers: radius 0 and zero height act as one.
    set_frame(0, 1, 0);
    add_frame(1, 1, 1, 1'b0);
    drain();
    // Radius above the maximum, a frame taller than the line ring.
    set_frame(15, 3, 20);
    add_frame(3, 20, MAXR, 1'b0);
    drain();
    // A narrow frame that wraps the line ring several times.
    set_frame(2, 1, 64);
    add_frame(1, 64, 2, 1'b0);
    drain();

    // Random frames. The second one runs under a long receiver hold-off so the
    // block fills and stalls its input; another runs with no idling at all.
    rand_cnt = 0;
    for (int f = 0; rand_cnt < 400; f++) begin
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAXR) : $urandom_range(1, 3);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      if (f == 1) begin
        r = 1;
        w = 8;
        h = 6;
      end
      set_frame(r, w, h);
      idle_en = (f != 3);
      add_frame(w, h, r, $urandom_range(0, 2) == 0);
      if (f == 1) hold_go = ~hold_go;
      rand_cnt += w * h;
      drain();
    end
    idle_en = 1'b1;

    if (fails == 0) begin
      $display("one_sided_box_filter_pass_core test passed");
    end else begin
      $display("one_sided_box_filter_pass_core test failed");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("one_sided_box_filter_pass_core test failed");
    $finish;
  end

endmodule
